/* rtl/text_console_cell_writer_core_defines.svh */
// ----------------------------------------------------------------------------
// text console cell writer - assertion macros
// concurrent checks on the rising edge of i_clk, off while reset is low
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CELL_WRITER_CORE_DEFINES_SVH
`define TEXT_CONSOLE_CELL_WRITER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define TCCW_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tccw check failed");
// next-cycle implication
`define TCCW_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tccw check failed");
`else
`define TCCW_ASSERT_IMP(lbl, ante, cons)
`define TCCW_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

/* rtl/tccw_pkg.sv */
// ----------------------------------------------------------------------------
// tccw_pkg
// shared types and constants of the text console cell writer
// ----------------------------------------------------------------------------
`default_nettype none

package tccw_pkg;

    localparam int TCCW_COLUMNS = 80;
    localparam int TCCW_ROWS    = 25;

    localparam logic [7:0] NEWLINE_CHAR = 8'd10;
    localparam logic [7:0] SPACE_CHAR   = 8'h20;
    localparam logic [7:0] RESET_ATTR   = 8'h07;

    // operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_ROW,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

/* rtl/tccw_ram.sv */
// ----------------------------------------------------------------------------
// tccw_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module tccw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/text_console_cell_writer_core.sv */
// ----------------------------------------------------------------------------
// text_console_cell_writer_core
// character-cell text console with cursor, line wrap and scroll
// ----------------------------------------------------------------------------
// input items (i_valid / o_stall): a write stores i_character at the cursor
//   with the current attribute and moves the cursor, byte 10 is a newline
//   that only moves it; a read returns the cell at i_read_row / i_read_column,
//   zero outside the screen
// result items (o_valid / i_stall): one per input item with the cell read,
//   the cursor after the item and a scroll flag
// i_cfg_wr_en / i_cfg_wr_data write the attribute byte, only while idle (not enforced by the block)
// one item at a time; from acceptance to the result register a write that
//   stays on its row passes S_DONE, a row change (newline, wrap, scroll)
//   passes S_ROW then S_DONE, a read S_READ then S_DONE; the next item is
//   taken in S_IDLE after the result loads. S_ROW writes the row table,
//   S_READ reads the cell ram; a scroll rotates a top-row pointer, no line copy
// reset: cursor home, attribute 0x07, per-row valid bits clear so every cell
//   reads as a light-grey space with no clear pass
// a stalled result waits in the output register; a finished item holds its
//   result internally until that register is free
// ----------------------------------------------------------------------------
`default_nettype none
`include "text_console_cell_writer_core_defines.svh"

module text_console_cell_writer_core
    import tccw_pkg::*;
#(
    parameter int COLUMNS = TCCW_COLUMNS,
    parameter int ROWS    = TCCW_ROWS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration
    input  wire logic        i_cfg_wr_en,
    input  wire logic [7:0]  i_cfg_wr_data,
    // input channel
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_operation,
    input  wire logic [7:0]  i_character,
    input  wire logic [4:0]  i_read_row,
    input  wire logic [6:0]  i_read_column,
    // output channel
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [15:0]      o_cell_value,
    output logic [4:0]       o_cursor_row,
    output logic [6:0]       o_cursor_column,
    output logic             o_scrolled
);

    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int FW    = $clog2(COLUMNS + 1);
    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);

    // control state
    t_state             r_state, n_state;
    logic [RW-1:0]      r_row, n_row;           // logical cursor row
    logic [CW-1:0]      r_col, n_col;           // cursor column
    logic [RW-1:0]      r_cur_phys, n_cur_phys; // physical row under the cursor
    logic [RW-1:0]      r_top, n_top;           // physical row of logical row 0
    logic [7:0]         r_cur_attr, n_cur_attr; // blank attribute of the cursor row
    logic [7:0]         r_attr;
    logic [ROWS-1:0]    r_row_valid, n_row_valid;
    logic               r_out_valid, n_out_valid;

    // payload
    logic [15:0]        r_res_cell, n_res_cell;
    logic               r_res_scr, n_res_scr;
    logic [RW-1:0]      r_rd_phys, n_rd_phys;
    logic [CW-1:0]      r_rd_col, n_rd_col;
    logic               r_rd_ok, n_rd_ok;
    logic [15:0]        r_out_cell, n_out_cell;
    logic [4:0]         r_out_row, n_out_row;
    logic [6:0]         r_out_col, n_out_col;
    logic               r_out_scr, n_out_scr;

    // ram ports
    logic               w_cell_we, w_cell_re;
    logic [AW-1:0]      w_cell_waddr, w_cell_raddr;
    logic [15:0]        w_cell_wdata, w_cell_q;
    logic               w_rowm_we, w_rowm_re;
    logic [RW-1:0]      w_rowm_waddr, w_rowm_raddr;
    logic [FW+7:0]      w_rowm_wdata, w_rowm_q;

    // decode of the incoming item
    logic               w_accept, w_is_read, w_is_nl;
    logic [CW:0]        w_col_inc;
    logic               w_wrap, w_adv, w_scroll, w_load;
    logic [RW-1:0]      w_phys_inc, w_top_inc;
    logic               w_rd_ok;
    logic [RW-1:0]      w_rr_eff;
    logic [CW-1:0]      w_rc_eff;
    logic [RW:0]        w_rd_sum;
    logic [RW-1:0]      w_rd_phys;
    logic [AW-1:0]      w_cur_addr;
    logic [FW-1:0]      w_fill;

    assign w_accept  = i_valid && (r_state == S_IDLE);
    assign w_is_read = (i_operation == OP_READ);
    assign w_is_nl   = (i_character == NEWLINE_CHAR);
    assign w_col_inc = {1'b0, r_col} + (CW + 1)'(1);
    assign w_wrap    = (w_col_inc == (CW + 1)'(COLUMNS));
    // cursor leaves its row: newline or wrap past the last column
    assign w_adv     = w_accept && !w_is_read && (w_is_nl || w_wrap);
    assign w_scroll  = w_adv && (r_row == RW'(ROWS - 1));

    // physical rows rotate through the ring
    assign w_phys_inc = (r_cur_phys == RW'(ROWS - 1)) ? '0 : r_cur_phys + RW'(1);
    assign w_top_inc  = (r_top == RW'(ROWS - 1)) ? '0 : r_top + RW'(1);

    // read address, out-of-screen reads are forced to row 0, column 0
    assign w_rd_ok   = (32'(i_read_row) < ROWS) && (32'(i_read_column) < COLUMNS);
    assign w_rr_eff  = w_rd_ok ? RW'(i_read_row) : '0;
    assign w_rc_eff  = w_rd_ok ? CW'(i_read_column) : '0;
    assign w_rd_sum  = (RW + 1)'(w_rr_eff) + (RW + 1)'(r_top);
    assign w_rd_phys = (w_rd_sum >= (RW + 1)'(ROWS)) ? RW'(w_rd_sum - (RW + 1)'(ROWS))
                                                     : RW'(w_rd_sum);

    assign w_cur_addr = AW'(32'(r_cur_phys) * COLUMNS + 32'(r_col));
    assign w_fill     = w_rowm_q[FW+7:8];

    assign w_load = (r_state == S_DONE) && (!r_out_valid || !i_stall);

    // cell store: one entry per physical cell
    tccw_ram #(
        .WIDTH (16),
        .DEPTH (CELLS)
    ) u_cell_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_cell_we),
        .i_wr_addr (w_cell_waddr),
        .i_wr_data (w_cell_wdata),
        .i_rd_en   (w_cell_re),
        .i_rd_addr (w_cell_raddr),
        .o_rd_data (w_cell_q)
    );

    // row table: written-cell count and blank attribute of each physical row
    tccw_ram #(
        .WIDTH (FW + 8),
        .DEPTH (ROWS)
    ) u_row_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_rowm_we),
        .i_wr_addr (w_rowm_waddr),
        .i_wr_data (w_rowm_wdata),
        .i_rd_en   (w_rowm_re),
        .i_rd_addr (w_rowm_raddr),
        .o_rd_data (w_rowm_q)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_is_read) begin
                        n_state = S_READ;
                    end else if (w_adv) begin
                        n_state = S_ROW;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_READ:  n_state = S_DONE;
            S_ROW:   n_state = S_DONE;
            S_DONE: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_row        = r_row;
        n_col        = r_col;
        n_cur_phys   = r_cur_phys;
        n_top        = r_top;
        n_cur_attr   = r_cur_attr;
        n_row_valid  = r_row_valid;
        n_res_cell   = r_res_cell;
        n_res_scr    = r_res_scr;
        n_rd_phys    = r_rd_phys;
        n_rd_col     = r_rd_col;
        n_rd_ok      = r_rd_ok;
        n_out_cell   = r_out_cell;
        n_out_row    = r_out_row;
        n_out_col    = r_out_col;
        n_out_scr    = r_out_scr;
        n_out_valid  = i_stall ? r_out_valid : 1'b0;
        w_cell_we    = 1'b0;
        w_cell_waddr = w_cur_addr;
        w_cell_wdata = {r_attr, i_character};
        w_cell_re    = 1'b0;
        w_cell_raddr = AW'(32'(w_rd_phys) * COLUMNS + 32'(w_rc_eff));
        w_rowm_we    = 1'b0;
        w_rowm_waddr = r_cur_phys;
        w_rowm_wdata = {FW'(w_col_inc), r_cur_attr};
        w_rowm_re    = 1'b0;
        w_rowm_raddr = w_rd_phys;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_res_cell = '0;
                    n_res_scr  = 1'b0;
                    if (w_is_read) begin
                        w_cell_re = 1'b1;
                        w_rowm_re = 1'b1;
                        n_rd_phys = w_rd_phys;
                        n_rd_col  = w_rc_eff;
                        n_rd_ok   = w_rd_ok;
                    end else begin
                        if (!w_is_nl) begin
                            // store the glyph and grow the row's written count
                            w_cell_we               = 1'b1;
                            w_rowm_we               = 1'b1;
                            n_row_valid[r_cur_phys] = 1'b1;
                            n_col                   = CW'(w_col_inc);
                        end
                        if (w_adv) begin
                            n_col     = '0;
                            n_res_scr = w_scroll;
                            if (w_scroll) begin
                                // old top row becomes the new bottom row
                                n_cur_phys = r_top;
                                n_top      = w_top_inc;
                                n_cur_attr = r_attr;
                            end else begin
                                n_row      = r_row + RW'(1);
                                n_cur_phys = w_phys_inc;
                                n_cur_attr = RESET_ATTR;
                            end
                        end
                    end
                end
            end
            S_READ: begin
                if (!r_rd_ok) begin
                    n_res_cell = '0;
                end else if (!r_row_valid[r_rd_phys]) begin
                    n_res_cell = {RESET_ATTR, SPACE_CHAR};
                end else if (32'(r_rd_col) < 32'(w_fill)) begin
                    n_res_cell = w_cell_q;
                end else begin
                    // beyond the written part: blank in the row's attribute
                    n_res_cell = {w_rowm_q[7:0], SPACE_CHAR};
                end
            end
            S_ROW: begin
                // new cursor row starts empty
                w_rowm_we               = 1'b1;
                w_rowm_wdata            = {FW'(0), r_cur_attr};
                n_row_valid[r_cur_phys] = 1'b1;
            end
            S_DONE: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_out_cell  = r_res_cell;
                    n_out_row   = 5'(r_row);
                    n_out_col   = 7'(r_col);
                    n_out_scr   = r_res_scr;
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row       <= '0;
            r_col       <= '0;
            r_cur_phys  <= '0;
            r_top       <= '0;
            r_cur_attr  <= RESET_ATTR;
            r_attr      <= RESET_ATTR;
            r_row_valid <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_cur_phys  <= n_cur_phys;
            r_top       <= n_top;
            r_cur_attr  <= n_cur_attr;
            r_row_valid <= n_row_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_attr <= i_cfg_wr_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_res_cell <= n_res_cell;
        r_res_scr  <= n_res_scr;
        r_rd_phys  <= n_rd_phys;
        r_rd_col   <= n_rd_col;
        r_rd_ok    <= n_rd_ok;
        r_out_cell <= n_out_cell;
        r_out_row  <= n_out_row;
        r_out_col  <= n_out_col;
        r_out_scr  <= n_out_scr;
    end

    assign o_stall         = (r_state != S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_cell_value    = r_out_cell;
    assign o_cursor_row    = r_out_row;
    assign o_cursor_column = r_out_col;
    assign o_scrolled      = r_out_scr;

    // a scroll always leaves the cursor at the start of the bottom row
    `TCCW_ASSERT_IMP(a_scroll_cursor, o_valid && o_scrolled, (o_cursor_row == 5'(ROWS - 1)) && (o_cursor_column == 7'd0))
    // an accepted read goes through the memory read cycle
    `TCCW_ASSERT_NXT(a_read_path, i_valid && !o_stall && (i_operation == OP_READ), r_state == S_READ)
    // physical cursor row matches the logical row rotated by the top pointer
    `TCCW_ASSERT_IMP(a_ring_map, 1'b1, ((32'(r_top) + 32'(r_row)) == 32'(r_cur_phys)) || ((32'(r_top) + 32'(r_row)) == (32'(r_cur_phys) + ROWS)))

endmodule

`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - text console cell writer
// random and directed character / read items against an in-bench screen
// model, several attribute settings, random idle on both channels
// ----------------------------------------------------------------------------

module testbench;

    import tccw_pkg::*;

    localparam int COLS        = TCCW_COLUMNS;
    localparam int LINES       = TCCW_ROWS;
    localparam int IDLE_PCT    = 36;
    localparam int MAX_PRINTED = 40;
    localparam int PHASES      = 5;
    localparam int PHASE_ITEMS = 140;

    // one input item as it sits on the ports
    typedef struct packed {
        logic       op;
        logic [7:0] ch;
        logic [4:0] row;
        logic [6:0] col;
    } console_cmd_t;

    // one result item as it sits on the ports
    typedef struct packed {
        logic [15:0] cell_val;
        logic [4:0]  row;
        logic [6:0]  col;
        logic        scrolled;
    } console_reply_t;

    // ------------------------------------------------------------------------
    // clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------------
    logic i_clk          = 1'b0;
    logic i_rst_n        = 1'b0;
    logic i_cfg_wr_en    = 1'b0;
    logic [7:0] i_cfg_wr_data = 8'h00;
    logic i_valid        = 1'b0;
    logic i_operation    = OP_WRITE;
    logic [7:0] i_character   = 8'h00;
    logic [4:0] i_read_row    = 5'd0;
    logic [6:0] i_read_column = 7'd0;
    logic i_stall        = 1'b0;

    logic        o_stall;
    logic        o_valid;
    logic [15:0] o_cell_value;
    logic [4:0]  o_cursor_row;
    logic [6:0]  o_cursor_column;
    logic        o_scrolled;

    text_console_cell_writer_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_operation     (i_operation),
        .i_character     (i_character),
        .i_read_row      (i_read_row),
        .i_read_column   (i_read_column),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_cell_value    (o_cell_value),
        .o_cursor_row    (o_cursor_row),
        .o_cursor_column (o_cursor_column),
        .o_scrolled      (o_scrolled)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // screen model: cursor, attribute and every cell
    // ------------------------------------------------------------------------
    logic [15:0] screen_model [COLS*LINES];
    logic [7:0]  attr_model;
    int          cursor_row_model;
    int          cursor_col_model;

    console_cmd_t   console_cmds_q[$];    // items waiting to be offered
    console_reply_t console_replies_q[$]; // replies owed by the block, oldest first

    int  mismatches  = 0;
    int  items_sent  = 0;
    int  reads_sent  = 0;
    int  scrolls_due = 0;
    int  wraps_due   = 0;
    int  replies_got = 0;
    int  attr_writes = 0;
    bit  calm_phase  = 1'b0; // no idling on either side while set

    // move to column 0 of the next row, scrolling off the bottom; 1 on scroll
    function automatic bit advance_row();
        cursor_col_model = 0;
        cursor_row_model++;
        if (cursor_row_model >= LINES) begin
            for (int i = 0; i < (LINES-1)*COLS; i++)
                screen_model[i] = screen_model[i+COLS];
            for (int i = 0; i < COLS; i++)
                screen_model[(LINES-1)*COLS + i] = {attr_model, SPACE_CHAR};
            cursor_row_model = LINES - 1;
            scrolls_due++;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // apply one accepted item to the screen and return the reply it owes
    function automatic console_reply_t apply_console_item(console_cmd_t c);
        console_reply_t r;
        r = '0;
        if (c.op == OP_READ) begin
            // outside the screen reads as zero
            if (int'(c.row) < LINES && int'(c.col) < COLS)
                r.cell_val = screen_model[int'(c.row)*COLS + int'(c.col)];
        end else if (c.ch == NEWLINE_CHAR) begin
            r.scrolled = advance_row();
        end else begin
            screen_model[cursor_row_model*COLS + cursor_col_model] = {attr_model, c.ch};
            cursor_col_model++;
            if (cursor_col_model >= COLS) begin
                wraps_due++;
                r.scrolled = advance_row();
            end
        end
        r.row = cursor_row_model[4:0];
        r.col = cursor_col_model[6:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("%0t mismatch on reply %0d: %s got 0x%0h want 0x%0h",
                     $realtime, replies_got, what, got, want);
    endtask

    // ------------------------------------------------------------------------
    // driver: offers queued items, idles at random, holds a stalled item
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_items
        console_cmd_t nxt;
        bit           taken;
        taken = i_valid && !o_stall;
        if (taken) begin
            // the ports still show the item that was just accepted
            console_replies_q.push_back(apply_console_item(
                {i_operation, i_character, i_read_row, i_read_column}));
            items_sent++;
            if (i_operation == OP_READ)
                reads_sent++;
        end
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !taken) begin
            // stalled: valid and payload stay as they are
        end else if (console_cmds_q.size() > 0 &&
                     (calm_phase || $urandom_range(0, 99) >= IDLE_PCT)) begin
            nxt = console_cmds_q.pop_front();
            i_valid       <= 1'b1;
            i_operation   <= nxt.op;
            i_character   <= nxt.ch;
            i_read_row    <= nxt.row;
            i_read_column <= nxt.col;
        end else begin
            i_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // monitor: stalls at random, checks every reply against the oldest owed
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : check_replies
        console_reply_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (console_replies_q.size() == 0) begin
                report_mismatch("reply with nothing owed, cell", int'(o_cell_value), 0);
            end else begin
                want = console_replies_q.pop_front();
                if (o_cell_value !== want.cell_val)
                    report_mismatch("cell_value", int'(o_cell_value), int'(want.cell_val));
                if (o_cursor_row !== want.row)
                    report_mismatch("cursor_row", int'(o_cursor_row), int'(want.row));
                if (o_cursor_column !== want.col)
                    report_mismatch("cursor_column", int'(o_cursor_column), int'(want.col));
                if (o_scrolled !== want.scrolled)
                    report_mismatch("scrolled", int'(o_scrolled), int'(want.scrolled));
            end
            replies_got++;
        end
        i_stall <= i_rst_n && !calm_phase && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic console_cmd_t char_item(logic [7:0] ch);
        console_cmd_t c;
        // the read position is don't-care on a write, so it gets noise
        c.op  = OP_WRITE;
        c.ch  = ch;
        c.row = 5'($urandom);
        c.col = 7'($urandom);
        return c;
    endfunction

    function automatic console_cmd_t read_item(logic [4:0] row, logic [6:0] col);
        console_cmd_t c;
        c.op  = OP_READ;
        c.ch  = 8'($urandom); // ignored on a read
        c.row = row;
        c.col = col;
        return c;
    endfunction

    // wait until nothing is queued, offered or owed; sampled off the rising edge
    task automatic wait_for_drain();
        do
            @(negedge i_clk);
        while (console_cmds_q.size() != 0 || i_valid || console_replies_q.size() != 0);
    endtask

    // attribute write while the block is idle
    task automatic set_text_attribute(input logic [7:0] value);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        attr_model = value;
        attr_writes++;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= 8'($urandom);
        @(negedge i_clk);
    endtask

    // console traffic: mostly text with newlines, long lines that wrap,
    // newline runs that push the cursor to the bottom, and cell reads
    task automatic queue_console_traffic(input int count);
        int  n;
        int  pick;
        int  len;
        logic [7:0] ch;
        n = 0;
        while (n < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                // a long run without newlines so the line wraps
                len = $urandom_range(60, 170);
                for (int i = 0; i < len; i++) begin
                    ch = 8'($urandom);
                    if (ch == NEWLINE_CHAR)
                        ch = SPACE_CHAR;
                    console_cmds_q.push_back(char_item(ch));
                end
                n += len;
            end else if (pick < 20) begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                    console_cmds_q.push_back(char_item(NEWLINE_CHAR));
                n += len;
            end else if (pick < 70) begin
                console_cmds_q.push_back(char_item(8'($urandom)));
                n++;
            end else if (pick < 93) begin
                console_cmds_q.push_back(read_item(5'($urandom_range(0, LINES-1)),
                                                   7'($urandom_range(0, COLS-1))));
                n++;
            end else begin
                // any position at all, mostly off the screen
                console_cmds_q.push_back(read_item(5'($urandom), 7'($urandom)));
                n++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // run sequence
    // ------------------------------------------------------------------------
    initial begin : run_phases
        logic [7:0] attr_plan [PHASES];

        // reset value first, then both extremes, a random byte and a typical one
        attr_plan[0] = RESET_ATTR;
        attr_plan[1] = 8'h00;
        attr_plan[2] = 8'hFF;
        attr_plan[3] = 8'($urandom_range(1, 254));
        attr_plan[4] = 8'h1E;

        // model after reset: light-grey spaces, cursor home
        attr_model       = RESET_ATTR;
        cursor_row_model = 0;
        cursor_col_model = 0;
        for (int i = 0; i < COLS*LINES; i++)
            screen_model[i] = {RESET_ATTR, SPACE_CHAR};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // phase 0 directed: reset contents, the screen edges, reads off the
        // screen, extreme characters, newline, then read back what was stored
        console_cmds_q.push_back(read_item(5'd0, 7'd0));
        console_cmds_q.push_back(read_item(5'(LINES-1), 7'(COLS-1)));
        console_cmds_q.push_back(read_item(5'(LINES), 7'd0));
        console_cmds_q.push_back(read_item(5'd0, 7'(COLS)));
        console_cmds_q.push_back(read_item(5'h1F, 7'h7F));
        console_cmds_q.push_back(char_item(8'h41));
        console_cmds_q.push_back(char_item(8'h00));
        console_cmds_q.push_back(char_item(8'hFF));
        console_cmds_q.push_back(char_item(NEWLINE_CHAR));
        console_cmds_q.push_back(char_item(8'h7E));
        console_cmds_q.push_back(read_item(5'd0, 7'd0));
        console_cmds_q.push_back(read_item(5'd0, 7'd1));
        console_cmds_q.push_back(read_item(5'd0, 7'd2));
        console_cmds_q.push_back(read_item(5'd0, 7'd3));
        console_cmds_q.push_back(read_item(5'd1, 7'd0));
        console_cmds_q.push_back(read_item(5'd1, 7'd1));
        console_cmds_q.push_back(char_item(NEWLINE_CHAR));
        console_cmds_q.push_back(char_item(NEWLINE_CHAR));

        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                // the sender holds off here until every owed reply is back
                wait_for_drain();
                set_text_attribute(attr_plan[p]);
                // an attribute change must not touch cells already shown
                console_cmds_q.push_back(read_item(5'd0, 7'd0));
                console_cmds_q.push_back(char_item(8'h5A));
                console_cmds_q.push_back(read_item(5'(cursor_row_model),
                                                   7'(cursor_col_model)));
            end
            // one phase runs with no idling at all on either side
            calm_phase = (p == 2);
            queue_console_traffic(PHASE_ITEMS);
        end

        wait_for_drain();
        // room for a stray reply to show up
        repeat (20) @(posedge i_clk);

        $display("covered %0d items: %0d reads, %0d writes, %0d line wraps, %0d scrolls",
                 items_sent, reads_sent, items_sent - reads_sent, wraps_due, scrolls_due);
        $display("%0d attribute writes, %0d replies checked, %0d mismatches",
                 attr_writes, replies_got, mismatches);
        if (mismatches == 0 && console_replies_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // hang guard, far above the slowest legal run
    initial begin : watchdog
        #500000;
        $display("timeout with %0d replies still owed", console_replies_q.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
